@@ rtl/hrfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Hit record frame encoder package
// Shared constants, command word layout and status types.
// ----------------------------------------------------------------------------
package hrfe_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_BET_SCALE   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENTRIES = 4'd1;

  localparam logic [9:0] BET_SCALE_RESET   = 10'd1;
  localparam logic [7:0] MAX_ENTRIES_RESET = 8'd99;

  localparam logic [7:0] HDR0 = 8'h55;
  localparam logic [7:0] HDR1 = 8'hE1;
  localparam logic [7:0] HDR2 = 8'hCC;
  localparam logic [7:0] TRL0 = 8'h68;
  localparam logic [7:0] TRL1 = 8'h16;

  // Byte positions inside one record's output sequence
  localparam logic [3:0] POS_HDR0    = 4'd0;
  localparam logic [3:0] POS_HDR1    = 4'd1;
  localparam logic [3:0] POS_HDR2    = 4'd2;
  localparam logic [3:0] POS_COUNT   = 4'd3;
  localparam logic [3:0] POS_ID_LO   = 4'd4;
  localparam logic [3:0] POS_ID_HI   = 4'd5;
  localparam logic [3:0] POS_PLAYER  = 4'd6;
  localparam logic [3:0] POS_BET_LO  = 4'd7;
  localparam logic [3:0] POS_BET_HI  = 4'd8;
  localparam logic [3:0] POS_PAY0    = 4'd9;
  localparam logic [3:0] POS_PAY1    = 4'd10;
  localparam logic [3:0] POS_PAY2    = 4'd11;
  localparam logic [3:0] POS_PAY3    = 4'd12;
  localparam logic [3:0] POS_CSUM    = 4'd13;
  localparam logic [3:0] POS_TRL0    = 4'd14;
  localparam logic [3:0] POS_TRL1    = 4'd15;

  typedef struct packed {
    logic        hdr;
    logic [7:0]  count;
    logic        take;
    logic [15:0] hit_id;
    logic [7:0]  player_id;
    logic [15:0] bet;
    logic [31:0] payout;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
    cmd_t head;
  } qstat_t;

  typedef struct packed {
    logic emit;
    logic pop;
  } bstat_t;

endpackage

@@ rtl/hrfe_front.sv @@
// ----------------------------------------------------------------------------
// Hit record frame encoder front end
// Holds configuration, tracks frame state and turns records into commands.
// ----------------------------------------------------------------------------
module hrfe_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hrfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hrfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               accept,
  input  logic [15:0]                        hit_id,
  input  logic [7:0]                         player_id,
  input  logic [7:0]                         bet_value,
  input  logic [31:0]                        payout,
  input  logic [7:0]                         frame_count,
  input  logic                               last_entry,
  output hrfe_pkg::push_t                    push,
  output logic                               in_frame
);

  logic [9:0]  bet_scale;
  logic [7:0]  max_entries;
  logic [7:0]  records_taken;
  logic [7:0]  rec_now;
  logic        take;
  logic [17:0] product;

  always_ff @(posedge clk) begin
    if (rst) begin
      bet_scale     <= hrfe_pkg::BET_SCALE_RESET;
      max_entries   <= hrfe_pkg::MAX_ENTRIES_RESET;
      in_frame      <= 1'b0;
      records_taken <= 8'd0;
    end else begin
      if (cfg_we && cfg_index == hrfe_pkg::REG_BET_SCALE) begin
        bet_scale <= cfg_data[9:0];
      end
      if (cfg_we && cfg_index == hrfe_pkg::REG_MAX_ENTRIES) begin
        max_entries <= cfg_data[7:0];
      end
      if (accept) begin
        if (last_entry) begin
          in_frame      <= 1'b0;
          records_taken <= 8'd0;
        end else begin
          in_frame      <= 1'b1;
          records_taken <= rec_now + {7'd0, take};
        end
      end
    end
  end

  assign rec_now = in_frame ? records_taken : 8'd0;
  assign take    = rec_now < max_entries;
  assign product = bet_value * bet_scale;

  always_comb begin
    push.push           = accept;
    push.cmd.hdr        = !in_frame;
    push.cmd.count      = (frame_count > max_entries) ? max_entries : frame_count;
    push.cmd.take       = take;
    push.cmd.hit_id     = hit_id;
    push.cmd.player_id  = player_id;
    push.cmd.bet        = product[15:0];
    push.cmd.payout     = payout;
    push.cmd.last       = last_entry;
  end

endmodule

@@ rtl/hrfe_queue.sv @@
// ----------------------------------------------------------------------------
// Hit record frame encoder command queue
// Two-entry queue between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module hrfe_queue (
  input  logic             clk,
  input  logic             rst,
  input  hrfe_pkg::push_t  push,
  input  logic             pop,
  output hrfe_pkg::qstat_t stat
);

  hrfe_pkg::cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign do_push = push.push && fill != 2'd2;
  assign do_pop  = pop && fill != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_comb begin
    stat.empty = fill == 2'd0;
    stat.full  = fill == 2'd2;
    stat.head  = mem[rd_ptr];
  end

endmodule

@@ rtl/hrfe_back.sv @@
// ----------------------------------------------------------------------------
// Hit record frame encoder back end
// Walks the head command byte by byte, keeps the checksum, drives the output.
// ----------------------------------------------------------------------------
module hrfe_back (
  input  logic             clk,
  input  logic             rst,
  input  hrfe_pkg::qstat_t qstat,
  input  logic             out_stall,
  output hrfe_pkg::bstat_t bstat,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             last_byte
);

  hrfe_pkg::cmd_t cmd;
  logic       started;
  logic [3:0] pos;
  logic [3:0] cur;
  logic [3:0] pos_next;
  logic       done;
  logic       nothing;
  logic       can_load;
  logic       emit;
  logic [7:0] sum;
  logic [7:0] byte_sel;

  assign cmd      = qstat.head;
  assign nothing  = !cmd.hdr && !cmd.take && !cmd.last;
  assign can_load = !out_valid || !out_stall;
  assign emit     = !qstat.empty && !nothing && can_load;

  always_comb begin
    if (started) begin
      cur = pos;
    end else if (cmd.hdr) begin
      cur = hrfe_pkg::POS_HDR0;
    end else if (cmd.take) begin
      cur = hrfe_pkg::POS_ID_LO;
    end else begin
      cur = hrfe_pkg::POS_CSUM;
    end
  end

  always_comb begin
    pos_next = cur + 4'd1;
    done     = 1'b0;
    if (cur == hrfe_pkg::POS_COUNT) begin
      if (cmd.take) begin
        pos_next = hrfe_pkg::POS_ID_LO;
      end else if (cmd.last) begin
        pos_next = hrfe_pkg::POS_CSUM;
      end else begin
        done = 1'b1;
      end
    end else if (cur == hrfe_pkg::POS_PAY3) begin
      if (cmd.last) begin
        pos_next = hrfe_pkg::POS_CSUM;
      end else begin
        done = 1'b1;
      end
    end else if (cur == hrfe_pkg::POS_TRL1) begin
      done = 1'b1;
    end
  end

  always_comb begin
    unique case (cur)
      hrfe_pkg::POS_HDR0:   byte_sel = hrfe_pkg::HDR0;
      hrfe_pkg::POS_HDR1:   byte_sel = hrfe_pkg::HDR1;
      hrfe_pkg::POS_HDR2:   byte_sel = hrfe_pkg::HDR2;
      hrfe_pkg::POS_COUNT:  byte_sel = cmd.count;
      hrfe_pkg::POS_ID_LO:  byte_sel = cmd.hit_id[7:0];
      hrfe_pkg::POS_ID_HI:  byte_sel = cmd.hit_id[15:8];
      hrfe_pkg::POS_PLAYER: byte_sel = cmd.player_id;
      hrfe_pkg::POS_BET_LO: byte_sel = cmd.bet[7:0];
      hrfe_pkg::POS_BET_HI: byte_sel = cmd.bet[15:8];
      hrfe_pkg::POS_PAY0:   byte_sel = cmd.payout[7:0];
      hrfe_pkg::POS_PAY1:   byte_sel = cmd.payout[15:8];
      hrfe_pkg::POS_PAY2:   byte_sel = cmd.payout[23:16];
      hrfe_pkg::POS_PAY3:   byte_sel = cmd.payout[31:24];
      hrfe_pkg::POS_CSUM:   byte_sel = sum;
      hrfe_pkg::POS_TRL0:   byte_sel = hrfe_pkg::TRL0;
      hrfe_pkg::POS_TRL1:   byte_sel = hrfe_pkg::TRL1;
      default:              byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      pos       <= hrfe_pkg::POS_HDR0;
      sum       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        started <= !done;
        pos     <= pos_next;
        sum     <= (cur == hrfe_pkg::POS_HDR0) ? hrfe_pkg::HDR0 : sum + byte_sel;
      end
      if (can_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      out_byte  <= byte_sel;
      last_byte <= cur == hrfe_pkg::POS_TRL1;
    end
  end

  always_comb begin
    bstat.emit = emit;
    bstat.pop  = !qstat.empty && (nothing || (emit && done));
  end

endmodule

@@ rtl/hit_record_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// Hit record frame encoder
// Serializes hit records into byte frames with header, count, checksum and
// trailer for a byte-wide serial link.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   hit_id player_id bet_value
//                                             payout frame_count last_entry
//   out      output     out_valid / out_stall out_byte last_byte
//   cfg      input      cfg_valid / cfg_ready cfg_index cfg_data
//
// One output byte per cycle while out_stall is low; a record expands to 3 to 16
// bytes (header 4, record 9, trailer 3, in any mix), a dropped record that
// neither opens nor closes the frame emits none and is popped from the queue.
// A two-entry command queue lets records be accepted while bytes still drain.
// Reset clears frame state, queue and output valid; registers take defaults.
// ----------------------------------------------------------------------------
module hit_record_frame_encoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hrfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hrfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      hit_id,
  input  logic [7:0]                       player_id,
  input  logic [7:0]                       bet_value,
  input  logic [31:0]                      payout,
  input  logic [7:0]                       frame_count,
  input  logic                             last_entry,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             last_byte
);

  hrfe_pkg::push_t  push;
  hrfe_pkg::qstat_t qstat;
  hrfe_pkg::bstat_t bstat;
  logic             accept;
  logic             in_frame;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign accept    = in_valid && !in_stall;

  hrfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .hit_id      (hit_id),
    .player_id   (player_id),
    .bet_value   (bet_value),
    .payout      (payout),
    .frame_count (frame_count),
    .last_entry  (last_entry),
    .push        (push),
    .in_frame    (in_frame)
  );

  hrfe_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (bstat.pop),
    .stat (qstat)
  );

  hrfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .out_stall (out_stall),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  a_last_is_trailer: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> out_byte == hrfe_pkg::TRL1)
    else $error("last_byte set on a byte other than the closing trailer");

  a_emit_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    bstat.emit |-> !qstat.empty)
    else $error("byte emitted with the command queue empty");

  a_last_closes_frame: assert property (@(posedge clk) disable iff (rst)
    accept && last_entry |=> !in_frame)
    else $error("frame still open after its last record");

endmodule
